@@ hw/rtl/tcw_pkg.sv @@
// Package for the text console writer: beat payload types, command and status
// structs between controller and datapath, function codes and character constants.
// No dependencies.
package tcw_pkg;

    localparam int CURSOR_W = 11;

    typedef enum logic [1:0] {
        FUNC_PRINT = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    typedef struct packed {
        logic [1:0] func;
        logic       use_cursor;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] char_code;
        logic [7:0] attr;
    } in_item_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [7:0]          cell_char;
        logic [7:0]          cell_attr;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic do_print;
        logic do_read;
        logic do_capture;
        logic do_clear;
        logic sweep_clr;
        logic scroll;
        logic fill;
        logic blank;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       scroll_req;
        logic       at_last_cell;
        logic       at_end;
    } status_t;

endpackage

@@ hw/rtl/text_console_writer.sv @@
// Top level of the text console writer: APB register, controller and datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
//
// A ROWS x COLS text screen with a cursor. A print or func 3 beat passes through the
// EXEC and DONE states to its result beat, and a read also passes through RDWAIT because
// of the registered RAM read. A print that moves the cursor past the last row scrolls the
// screen through the single RAM port pair, one cell a cycle. A clear writes every cell
// once. After reset every one of the ROWS*COLS cells (2000 by default) is swept to zero
// while in_stall is held high; the default_attr register is writable at any time.
module text_console_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tcw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tcw_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tcw_pkg::*;

    logic [7:0] default_attr_reg;
    cmd_t       cmd;
    status_t    status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            default_attr_reg <= pwdata[7:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, default_attr_reg};

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .default_attr (default_attr_reg),
        .cmd          (cmd),
        .status       (status),
        .out_data     (out_data)
    );
endmodule

@@ hw/rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// Controller for the text console writer: sequences each item, scroll and fill sweeps
// and the output beat. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        S_FILL   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_SCROLL = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   blank_reg, blank_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        blank_next     = blank_reg;
        cmd            = '0;
        cmd.blank      = blank_reg;
        unique case (state_reg)
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.at_last_cell)
                begin
                    state_next = blank_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (status.func)
                    FUNC_PRINT:
                    begin
                        cmd.do_print = 1'b1;
                        if (status.scroll_req)
                        begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = S_SCROLL;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_READ:
                    begin
                        cmd.do_read = 1'b1;
                        state_next  = S_RDWAIT;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.do_clear  = 1'b1;
                        cmd.sweep_clr = 1'b1;
                        blank_next    = 1'b1;
                        state_next    = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.do_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll = 1'b1;
                if (status.at_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            blank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blank_reg     <= blank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

@@ hw/rtl/tcw_dp.sv @@
// Datapath for the text console writer: item register, cursor, sweep counter,
// screen RAM and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dp #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tcw_pkg::in_item_t  in_data,
    input  logic [7:0]         default_attr,
    input  tcw_pkg::cmd_t      cmd,
    output tcw_pkg::status_t   status,
    output tcw_pkg::out_item_t out_data
);
    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int SW     = $clog2(NCELLS + 1);
    localparam int BODY   = NCELLS - COLS;

    in_item_t        item_reg;
    logic [RW-1:0]   cur_row_reg;
    logic [CW-1:0]   cur_col_reg;
    logic [SW-1:0]   cnt_reg;
    logic [7:0]      res_char_reg;
    logic [7:0]      res_attr_reg;
    out_item_t       out_reg;

    logic [RW-1:0]   row_cl, base_r;
    logic [CW-1:0]   col_cl, base_c;
    logic [RW:0]     nr;
    logic [CW:0]     nc;
    logic            newline, scroll_req;
    logic [7:0]      eff_attr;
    logic [AW-1:0]   print_idx, read_idx;

    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [15:0]     wr_data, rd_data;

    always_comb
    begin
        row_cl = (int'(item_reg.row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(item_reg.row);
        col_cl = (int'(item_reg.col) > COLS - 1) ? CW'(COLS - 1) : CW'(item_reg.col);
        base_r = item_reg.use_cursor ? cur_row_reg : row_cl;
        base_c = item_reg.use_cursor ? cur_col_reg : col_cl;
        newline = (item_reg.char_code == NEWLINE_CODE);
        eff_attr = (item_reg.attr == 8'd0) ? default_attr : item_reg.attr;
        print_idx = AW'(int'(base_r) * COLS + int'(base_c));
        read_idx  = AW'(int'(row_cl) * COLS + int'(col_cl));
        if (newline)
        begin
            nc = '0;
            nr = {1'b0, base_r} + 1'b1;
        end
        else
        begin
            nc = {1'b0, base_c} + 1'b1;
            nr = {1'b0, base_r};
            if (nc == (CW+1)'(COLS))
            begin
                nc = '0;
                nr = {1'b0, base_r} + 1'b1;
            end
        end
        scroll_req = (nr == (RW+1)'(ROWS));
    end

    // Write port: a print, a scroll copy (written in the cycle after its read) or a fill.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = print_idx;
        wr_data = {eff_attr, item_reg.char_code};
        if (cmd.do_print)
        begin
            wr_en = !newline;
        end
        else if (cmd.scroll)
        begin
            wr_en   = (cnt_reg != '0);
            wr_addr = AW'(int'(cnt_reg) - 1);
            wr_data = (int'(cnt_reg) - 1 < BODY) ? rd_data : 16'd0;
        end
        else if (cmd.fill)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_reg);
            wr_data = (cmd.blank && int'(cnt_reg) < BODY) ? {default_attr, SPACE_CODE} : 16'd0;
        end
        if (cmd.do_read)
        begin
            rd_addr = read_idx;
        end
        else if (int'(cnt_reg) + COLS > NCELLS - 1)
        begin
            rd_addr = AW'(NCELLS - 1);
        end
        else
        begin
            rd_addr = AW'(int'(cnt_reg) + COLS);
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (NCELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (cmd.do_print)
            begin
                cur_row_reg <= scroll_req ? RW'(ROWS - 1) : nr[RW-1:0];
                cur_col_reg <= nc[CW-1:0];
            end
            if (cmd.sweep_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scroll || cmd.fill)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg     <= in_data;
            res_char_reg <= 8'd0;
            res_attr_reg <= 8'd0;
        end
        else if (cmd.do_print && !newline)
        begin
            res_char_reg <= item_reg.char_code;
            res_attr_reg <= eff_attr;
        end
        else if (cmd.do_capture)
        begin
            res_char_reg <= rd_data[7:0];
            res_attr_reg <= rd_data[15:8];
        end
        if (cmd.load_out)
        begin
            out_reg.cursor_cell <= CURSOR_W'(int'(cur_row_reg) * COLS + int'(cur_col_reg));
            out_reg.cell_char   <= res_char_reg;
            out_reg.cell_attr   <= res_attr_reg;
        end
    end

    assign status.func         = item_reg.func;
    assign status.scroll_req   = scroll_req;
    assign status.at_last_cell = (cnt_reg == SW'(NCELLS - 1));
    assign status.at_end       = (cnt_reg == SW'(NCELLS));
    assign out_data            = out_reg;
endmodule
